[rtl/unix_time_to_calendar_date_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the Unix time to calendar date block
// Concurrent assertion wrappers that are compiled out when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef UNIX_TIME_TO_CALENDAR_DATE_MACROS_SVH
`define UNIX_TIME_TO_CALENDAR_DATE_MACROS_SVH

`ifndef SYNTH

`define U2CD_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("u2cd: implication check failed");

`define U2CD_ASSERT_LATENCY(label, clk, rst_n, ante, dly, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##(dly) (cons)) \
    else $error("u2cd: latency check failed");

`else

`define U2CD_ASSERT_IMPLY(label, clk, rst_n, ante, cons)

`define U2CD_ASSERT_LATENCY(label, clk, rst_n, ante, dly, cons)

`endif

`endif

[rtl/u2cd_pkg.sv]
// ----------------------------------------------------------------------------
// u2cd_pkg
// Shared widths, division constants and result types of the date converter.
// ----------------------------------------------------------------------------
package u2cd_pkg;

  localparam int SecondsW = 32;
  localparam int DaysW    = 16;
  localparam int SodW     = 17;
  localparam int YearW    = 12;
  localparam int MonthW   = 4;
  localparam int MdayW    = 5;
  localparam int HourW    = 5;
  localparam int MinuteW  = 6;
  localparam int SecondW  = 6;
  localparam int WdayW    = 3;

  // Seconds per day is 128 * 675.
  localparam int DayShift = 7;
  localparam logic [9:0]  DayDiv      = 10'd675;
  localparam logic [15:0] DayRecip    = 16'd49710;
  localparam int          DayRecipSh  = 25;

  localparam logic [11:0] MinRecip    = 12'd2184;
  localparam logic [5:0]  HourRecip   = 6'd36;
  localparam logic [14:0] WdayRecip   = 15'd18724;
  localparam int          SodRecipSh  = 17;
  localparam logic [5:0]  SecPerMin   = 6'd60;
  localparam logic [11:0] SecPerHour  = 12'd3600;
  localparam logic [2:0]  DaysPerWeek = 3'd7;
  localparam logic [2:0]  EpochWday   = 3'd4;

  // Start of the 400-year era that holds the epoch, and of the next one.
  localparam logic [15:0] EraSplitDay = 16'd11017;
  localparam logic [17:0] EraOffset   = 18'd135080;
  localparam logic [11:0] EraYearLo   = 12'd1600;
  localparam logic [11:0] EraYearHi   = 12'd2000;

  localparam logic [17:0] Days100y    = 18'd36524;
  localparam logic [5:0]  Recip4y     = 6'd44;
  localparam int          Recip4ySh   = 16;
  localparam logic [10:0] Days4y      = 11'd1461;
  localparam logic [8:0]  Days1y      = 9'd365;
  localparam logic [6:0]  YearsPerCent = 7'd100;

  localparam logic [8:0] MonthStart [12] = '{
    9'd0, 9'd31, 9'd61, 9'd92, 9'd122, 9'd153,
    9'd184, 9'd214, 9'd245, 9'd275, 9'd306, 9'd337
  };

  typedef struct packed {
    logic [HourW-1:0]   hour;
    logic [MinuteW-1:0] minute;
    logic [SecondW-1:0] second;
    logic [WdayW-1:0]   weekday;
  } tod_t;

  typedef struct packed {
    logic [YearW-1:0]  year;
    logic [MonthW-1:0] month;
    logic [MdayW-1:0]  mday;
  } date_t;

endpackage

[rtl/u2cd_day_split.sv]
// ----------------------------------------------------------------------------
// u2cd_day_split
// Two-stage split of the second count into whole days and seconds of the day.
// ----------------------------------------------------------------------------
module u2cd_day_split (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  input  logic [u2cd_pkg::SecondsW-1:0]    unix_seconds,
  output logic                             out_valid,
  output logic [u2cd_pkg::DaysW-1:0]       days,
  output logic [u2cd_pkg::SodW-1:0]        sod
);

  localparam int XW = u2cd_pkg::SecondsW - u2cd_pkg::DayShift;
  localparam int PW = XW + 16;

  logic [1:0]                     vld_r;
  logic [XW-1:0]                  x_r;
  logic [u2cd_pkg::DayShift-1:0]  lo_r;
  logic [PW-1:0]                  prod_r;
  logic [PW-1:0]                  prod_nxt;
  logic [u2cd_pkg::DaysW-1:0]     q_est;
  logic [XW:0]                    qm;
  logic [XW:0]                    rem_w;
  logic [10:0]                    rem;
  logic                           fix;
  logic [u2cd_pkg::DaysW-1:0]     days_nxt;
  logic [u2cd_pkg::DaysW-1:0]     days_r;
  logic [9:0]                     sod_hi;
  logic [u2cd_pkg::SodW-1:0]      sod_nxt;
  logic [u2cd_pkg::SodW-1:0]      sod_r;

  assign prod_nxt = PW'(unix_seconds[u2cd_pkg::SecondsW-1:u2cd_pkg::DayShift])
                  * PW'(u2cd_pkg::DayRecip);

  always_comb begin
    q_est    = prod_r[u2cd_pkg::DayRecipSh +: u2cd_pkg::DaysW];
    qm       = (XW+1)'(q_est) * (XW+1)'(u2cd_pkg::DayDiv);
    rem_w    = (XW+1)'(x_r) - qm;
    rem      = rem_w[10:0];
    fix      = rem >= 11'(u2cd_pkg::DayDiv);
    days_nxt = q_est + u2cd_pkg::DaysW'(fix);
    sod_hi   = fix ? 10'(rem - 11'(u2cd_pkg::DayDiv)) : rem[9:0];
    sod_nxt  = {sod_hi, lo_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    x_r    <= unix_seconds[u2cd_pkg::SecondsW-1:u2cd_pkg::DayShift];
    lo_r   <= unix_seconds[u2cd_pkg::DayShift-1:0];
    prod_r <= prod_nxt;
    days_r <= days_nxt;
    sod_r  <= sod_nxt;
  end

  assign out_valid = vld_r[1];
  assign days      = days_r;
  assign sod       = sod_r;

endmodule

[rtl/u2cd_clock.sv]
// ----------------------------------------------------------------------------
// u2cd_clock
// Three-stage conversion of seconds of the day to hour, minute and second,
// with the weekday taken from the day count.
// ----------------------------------------------------------------------------
module u2cd_clock (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic [u2cd_pkg::SodW-1:0]     sod,
  input  logic [u2cd_pkg::DaysW-1:0]    days,
  output logic                          out_valid,
  output u2cd_pkg::tod_t                tod
);

  logic [2:0]                      vld_r;

  logic [u2cd_pkg::SodW-1:0]       sod_r;
  logic [27:0]                     pm_r;
  logic [22:0]                     ph_r;
  logic [16:0]                     wx_r;
  logic [31:0]                     pw_r;
  logic [16:0]                     wx_nxt;

  logic [10:0]                     qmin;
  logic [16:0]                     rm_w;
  logic [6:0]                      rm;
  logic                            fixm;
  logic [5:0]                      qh;
  logic [16:0]                     rh_w;
  logic [12:0]                     rh;
  logic                            fixh;
  logic [14:0]                     qw;
  logic [16:0]                     rw_w;
  logic [3:0]                      rw;
  logic                            fixw;

  logic [10:0]                     mtot_nxt;
  logic [10:0]                     mtot_r;
  logic [u2cd_pkg::HourW-1:0]      hour_nxt;
  logic [u2cd_pkg::HourW-1:0]      hour_r;
  logic [u2cd_pkg::SecondW-1:0]    sec_nxt;
  logic [u2cd_pkg::SecondW-1:0]    sec_r;
  logic [u2cd_pkg::WdayW-1:0]      wday_nxt;
  logic [u2cd_pkg::WdayW-1:0]      wday_r;

  u2cd_pkg::tod_t                  tod_nxt;
  u2cd_pkg::tod_t                  tod_r;

  assign wx_nxt = 17'(days) + 17'(u2cd_pkg::EpochWday);

  always_comb begin
    qmin     = pm_r[u2cd_pkg::SodRecipSh +: 11];
    rm_w     = sod_r - 17'(qmin) * 17'(u2cd_pkg::SecPerMin);
    rm       = rm_w[6:0];
    fixm     = rm >= 7'(u2cd_pkg::SecPerMin);
    mtot_nxt = qmin + 11'(fixm);
    sec_nxt  = fixm ? 6'(rm - 7'(u2cd_pkg::SecPerMin)) : rm[5:0];

    qh       = ph_r[u2cd_pkg::SodRecipSh +: 6];
    rh_w     = sod_r - 17'(qh) * 17'(u2cd_pkg::SecPerHour);
    rh       = rh_w[12:0];
    fixh     = rh >= 13'(u2cd_pkg::SecPerHour);
    hour_nxt = 5'(qh + 6'(fixh));

    qw       = pw_r[u2cd_pkg::SodRecipSh +: 15];
    rw_w     = wx_r - 17'(qw) * 17'(u2cd_pkg::DaysPerWeek);
    rw       = rw_w[3:0];
    fixw     = rw >= 4'(u2cd_pkg::DaysPerWeek);
    wday_nxt = fixw ? 3'(rw - 4'(u2cd_pkg::DaysPerWeek)) : rw[2:0];
  end

  always_comb begin
    tod_nxt.hour    = hour_r;
    tod_nxt.minute  = 6'(mtot_r - 11'(hour_r) * 11'(u2cd_pkg::SecPerMin));
    tod_nxt.second  = sec_r;
    tod_nxt.weekday = wday_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[1:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    sod_r  <= sod;
    pm_r   <= 28'(sod) * 28'(u2cd_pkg::MinRecip);
    ph_r   <= 23'(sod) * 23'(u2cd_pkg::HourRecip);
    wx_r   <= wx_nxt;
    pw_r   <= 32'(wx_nxt) * 32'(u2cd_pkg::WdayRecip);
    mtot_r <= mtot_nxt;
    hour_r <= hour_nxt;
    sec_r  <= sec_nxt;
    wday_r <= wday_nxt;
    tod_r  <= tod_nxt;
  end

  assign out_valid = vld_r[2];
  assign tod       = tod_r;

endmodule

[rtl/u2cd_civil.sv]
// ----------------------------------------------------------------------------
// u2cd_civil
// Six-stage conversion of a day count to Gregorian year, month and day,
// splitting the days into 400-, 100-, 4- and 1-year cycles.
// ----------------------------------------------------------------------------
module u2cd_civil (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic [u2cd_pkg::DaysW-1:0]    days,
  output logic                          out_valid,
  output u2cd_pkg::date_t               date
);

  logic [5:0]                      vld_r;

  logic                            era_nxt;
  logic [17:0]                     doe_nxt;
  logic                            era_r;
  logic [17:0]                     doe_r;

  logic [3:0]                      cent_ge;
  logic [2:0]                      n100_nxt;
  logic [17:0]                     cent_sub;
  logic [15:0]                     doc_nxt;
  logic                            era4_r;
  logic [2:0]                      n100_r;
  logic [15:0]                     doc_r;

  logic                            era5_r;
  logic [2:0]                      n100_5_r;
  logic [15:0]                     doc_5_r;
  logic [21:0]                     p4_r;

  logic [5:0]                      q4;
  logic [15:0]                     dy_w;
  logic [11:0]                     dy_raw;
  logic                            fix4;
  logic [4:0]                      n4_nxt;
  logic [10:0]                     dy_nxt;
  logic [11:0]                     yc_nxt;
  logic [2:0]                      n100_6_r;
  logic [4:0]                      n4_r;
  logic [10:0]                     dy_r;
  logic [11:0]                     yc_r;

  logic [3:0]                      yr_ge;
  logic [2:0]                      n1;
  logic [10:0]                     yr_sub;
  logic [8:0]                      doy_nxt;
  logic                            feb_nxt;
  logic [11:0]                     year_nxt;
  logic [8:0]                      doy_r;
  logic                            feb_r;
  logic [11:0]                     year_r;

  logic [3:0]                      midx;
  logic [3:0]                      mon;
  u2cd_pkg::date_t                 date_nxt;
  u2cd_pkg::date_t                 date_r;

  always_comb begin
    era_nxt = days >= u2cd_pkg::EraSplitDay;
    doe_nxt = era_nxt ? 18'(days) - 18'(u2cd_pkg::EraSplitDay)
                      : 18'(days) + u2cd_pkg::EraOffset;
  end

  always_comb begin
    cent_ge[0] = doe_r >= u2cd_pkg::Days100y;
    cent_ge[1] = doe_r >= 18'(2) * u2cd_pkg::Days100y;
    cent_ge[2] = doe_r >= 18'(3) * u2cd_pkg::Days100y;
    cent_ge[3] = doe_r >= 18'(4) * u2cd_pkg::Days100y;
    n100_nxt   = 3'(cent_ge[0]) + 3'(cent_ge[1]) + 3'(cent_ge[2]) + 3'(cent_ge[3]);
    case (n100_nxt)
      3'd0:    cent_sub = '0;
      3'd1:    cent_sub = u2cd_pkg::Days100y;
      3'd2:    cent_sub = 18'(2) * u2cd_pkg::Days100y;
      3'd3:    cent_sub = 18'(3) * u2cd_pkg::Days100y;
      default: cent_sub = 18'(4) * u2cd_pkg::Days100y;
    endcase
    doc_nxt = 16'(doe_r - cent_sub);
  end

  always_comb begin
    q4     = p4_r[u2cd_pkg::Recip4ySh +: 6];
    dy_w   = doc_5_r - 16'(q4) * 16'(u2cd_pkg::Days4y);
    dy_raw = dy_w[11:0];
    fix4   = dy_raw >= 12'(u2cd_pkg::Days4y);
    n4_nxt = 5'(q4 + 6'(fix4));
    dy_nxt = fix4 ? 11'(dy_raw - 12'(u2cd_pkg::Days4y)) : dy_raw[10:0];
    yc_nxt = (era5_r ? u2cd_pkg::EraYearHi : u2cd_pkg::EraYearLo)
           + 12'(n100_5_r) * 12'(u2cd_pkg::YearsPerCent);
  end

  always_comb begin
    yr_ge[0] = dy_r >= 11'(u2cd_pkg::Days1y);
    yr_ge[1] = dy_r >= 11'(2) * 11'(u2cd_pkg::Days1y);
    yr_ge[2] = dy_r >= 11'(3) * 11'(u2cd_pkg::Days1y);
    yr_ge[3] = dy_r >= 11'(4) * 11'(u2cd_pkg::Days1y);
    n1       = 3'(yr_ge[0]) + 3'(yr_ge[1]) + 3'(yr_ge[2]) + 3'(yr_ge[3]);
    yr_sub   = 11'(n1) * 11'(u2cd_pkg::Days1y);
    doy_nxt  = 9'(dy_r - yr_sub);
    feb_nxt  = (n100_6_r == 3'd4) || (n1 == 3'd4);
    year_nxt = yc_r + {5'(n4_r), 2'b00} + 12'(n1);
  end

  always_comb begin
    midx = '0;
    for (int k = 1; k < 12; k++) begin
      midx = midx + 4'(doy_r >= u2cd_pkg::MonthStart[k]);
    end
    mon = midx + 4'd3;
    date_nxt.year  = year_r;
    date_nxt.month = mon;
    date_nxt.mday  = 5'(doy_r - u2cd_pkg::MonthStart[midx] + 9'd1);
    if (feb_r) begin
      date_nxt.month = 4'd2;
      date_nxt.mday  = 5'd29;
    end else if (mon > 4'd12) begin
      date_nxt.month = mon - 4'd12;
      date_nxt.year  = year_r + 12'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[4:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    era_r    <= era_nxt;
    doe_r    <= doe_nxt;
    era4_r   <= era_r;
    n100_r   <= n100_nxt;
    doc_r    <= doc_nxt;
    era5_r   <= era4_r;
    n100_5_r <= n100_r;
    doc_5_r  <= doc_r;
    p4_r     <= 22'(doc_r) * 22'(u2cd_pkg::Recip4y);
    n100_6_r <= n100_5_r;
    n4_r     <= n4_nxt;
    dy_r     <= dy_nxt;
    yc_r     <= yc_nxt;
    doy_r    <= doy_nxt;
    feb_r    <= feb_nxt;
    year_r   <= year_nxt;
    date_r   <= date_nxt;
  end

  assign out_valid = vld_r[5];
  assign date      = date_r;

endmodule

[rtl/unix_time_to_calendar_date.sv]
// ----------------------------------------------------------------------------
// unix_time_to_calendar_date
// Converts a 32-bit Unix second count to the UTC calendar date, time of day
// and weekday.
// ----------------------------------------------------------------------------
// A transaction enters when start is high while busy is low. Busy is always
// low, so a new timestamp may be presented on every clock cycle.
// Each transaction gives exactly one result, shown on the out_ ports for one
// cycle and marked by out_valid. The receiver cannot hold results off.
// Throughput is one transaction per cycle. The depth is set by the date path:
// two stages find the day count, then six stages split it into 400-, 100-,
// 4- and 1-year cycles and the month. Time of day and weekday take three
// stages and are delayed to meet the date.
// Reset clears only the valid pipeline, so no result is shown after reset
// until new transactions arrive. The block holds no other state.
// ----------------------------------------------------------------------------
`include "unix_time_to_calendar_date_macros.svh"

module unix_time_to_calendar_date (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic [u2cd_pkg::SecondsW-1:0]     in_unix_seconds,
  output logic                              out_valid,
  output logic [u2cd_pkg::YearW-1:0]        out_year,
  output logic [u2cd_pkg::MonthW-1:0]       out_month,
  output logic [u2cd_pkg::MdayW-1:0]        out_day_of_month,
  output logic [u2cd_pkg::HourW-1:0]        out_hour,
  output logic [u2cd_pkg::MinuteW-1:0]      out_minute,
  output logic [u2cd_pkg::SecondW-1:0]      out_second,
  output logic [u2cd_pkg::WdayW-1:0]        out_weekday
);

  logic                           split_vld;
  logic [u2cd_pkg::DaysW-1:0]     days;
  logic [u2cd_pkg::SodW-1:0]      sod;
  logic                           tod_vld;
  u2cd_pkg::tod_t                 tod;
  u2cd_pkg::tod_t                 tod_d1_r;
  u2cd_pkg::tod_t                 tod_d2_r;
  u2cd_pkg::tod_t                 tod_d3_r;
  logic                           date_vld;
  u2cd_pkg::date_t                date;

  assign busy = 1'b0;

  u2cd_day_split u_split (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (start && !busy),
    .unix_seconds (in_unix_seconds),
    .out_valid    (split_vld),
    .days         (days),
    .sod          (sod)
  );

  u2cd_clock u_clock (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (split_vld),
    .sod       (sod),
    .days      (days),
    .out_valid (tod_vld),
    .tod       (tod)
  );

  u2cd_civil u_civil (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (split_vld),
    .days      (days),
    .out_valid (date_vld),
    .date      (date)
  );

  always_ff @(posedge clk) begin
    tod_d1_r <= tod;
    tod_d2_r <= tod_d1_r;
    tod_d3_r <= tod_d2_r;
  end

  assign out_valid        = date_vld;
  assign out_year         = date.year;
  assign out_month        = date.month;
  assign out_day_of_month = date.mday;
  assign out_hour         = tod_d3_r.hour;
  assign out_minute       = tod_d3_r.minute;
  assign out_second       = tod_d3_r.second;
  assign out_weekday      = tod_d3_r.weekday;

  `U2CD_ASSERT_LATENCY(a_result_latency, clk, rst_n, start && !busy, 8, out_valid)
  `U2CD_ASSERT_IMPLY(a_clock_aligned, clk, rst_n, tod_vld, ##3 date_vld)
  `U2CD_ASSERT_IMPLY(a_month_range, clk, rst_n, out_valid, out_month >= 4'd1 && out_month <= 4'd12)
  `U2CD_ASSERT_IMPLY(a_feb_days, clk, rst_n, out_valid && out_month == 4'd2, out_day_of_month <= 5'd29)
  `U2CD_ASSERT_IMPLY(a_time_range, clk, rst_n, out_valid, out_hour <= 5'd23 && out_weekday <= 3'd6)

endmodule
